// ===== src/pidf_pkg.sv =====
// Shared types and constants for the filtered-derivative PID controller.
// Used by pidf_serial_md and pid_controller_filtered_derivative; no dependencies.
package pidf_pkg;

    // Default fraction width of gains, integrator and filtered derivative
    localparam int FRAC_BITS_DEF = 16;

    // Serial multiply/divide datapath widths
    localparam int DP_W   = 96;                 // widest product or dividend
    localparam int MP_W   = 32;                 // widest multiplier operand
    localparam int DV_W   = 20;                 // widest divisor
    localparam int STEP_W = $clog2(DP_W + 1);   // step counter

    localparam logic [DV_W-1:0] US_PER_S     = DV_W'(1000000);
    localparam logic [15:0]     FILTER_RESET = 16'd7958;

    // |error| * |ki| * dt stays below 2^78
    localparam int I_DIV_N = 80;

    // Operation codes on the func field
    typedef enum logic [2:0] {
        FN_PID   = 3'd0,
        FN_PI    = 3'd1,
        FN_P     = 3'd2,
        FN_I     = 3'd3,
        FN_D     = 3'd4,
        FN_CLEAR = 3'd5
    } pidf_func_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_INTEG_LIMIT = 3'd3,
        CFG_FILTER_TIME = 3'd4
    } pidf_cfg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_P_MUL,
        S_I_MUL_GAIN,
        S_I_MUL_DT,
        S_I_DIV,
        S_I_CLAMP,
        S_I_TERM,
        S_D_PRIME,
        S_D_MUL_FT,
        S_D_MUL_DE,
        S_D_DIV,
        S_D_MUL_KD,
        S_FINISH
    } pidf_state_t;

    // Command to the serial multiply/divide unit
    typedef struct packed {
        logic              start;
        logic              div;
        logic [STEP_W-1:0] steps;
    } pidf_md_cmd_t;

    // Status from the serial multiply/divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } pidf_md_sts_t;

endpackage

// ===== src/pidf_serial_md.sv =====
// Bit-serial unsigned multiply (shift-add) and restoring divide unit.
// Depends on pidf_pkg for widths and the command/status structs.
module pidf_serial_md (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pidf_pkg::pidf_md_cmd_t       cmd,
    input  logic [pidf_pkg::DP_W-1:0]    opa,
    input  logic [pidf_pkg::MP_W-1:0]    opb,
    input  logic [pidf_pkg::DV_W-1:0]    divisor,
    output pidf_pkg::pidf_md_sts_t       sts,
    output logic [pidf_pkg::DP_W-1:0]    result
);
    import pidf_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              div_reg, div_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DP_W-1:0]   sh_reg, sh_next;
    logic [DP_W-1:0]   acc_reg, acc_next;
    logic [MP_W-1:0]   mpl_reg, mpl_next;
    logic [DV_W-1:0]   dvs_reg, dvs_next;
    logic [DV_W-1:0]   rem_reg, rem_next;
    logic [DV_W:0]     trial;
    logic [DV_W:0]     diff;

    // Restoring divide: bring in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, sh_reg[DP_W-1]};
        diff  = trial - {1'b0, dvs_reg};
    end

    // One multiplier bit or one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        mpl_next  = mpl_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            div_next  = cmd.div;
            cnt_next  = cmd.steps;
            sh_next   = opa;
            acc_next  = '0;
            mpl_next  = opb;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg)
            begin
                // quotient bits enter at the bottom as dividend bits leave the top
                if (!diff[DV_W])
                begin
                    rem_next = diff[DV_W-1:0];
                    sh_next  = {sh_reg[DP_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DV_W-1:0];
                    sh_next  = {sh_reg[DP_W-2:0], 1'b0};
                end
            end
            else
            begin
                if (mpl_reg[0])
                begin
                    acc_next = acc_reg + sh_reg;
                end
                sh_next  = {sh_reg[DP_W-2:0], 1'b0};
                mpl_next = {1'b0, mpl_reg[MP_W-1:1]};
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result shift registers
    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        mpl_reg <= mpl_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign result = div_reg ? sh_reg : acc_reg;
    assign sts    = '{busy: busy_reg, done: done_reg};

endmodule

// ===== src/pid_controller_filtered_derivative.sv =====
// PID controller with clamped integrator and low-pass filtered derivative.
// Depends on pidf_pkg and pidf_serial_md (one shared bit-serial mul/div unit).
// One request at a time; the next is taken the cycle after the result loads the output
// register. Reset is asynchronous and resets configuration and controller state (the
// filter time to FILTER_RESET); the payload registers are not reset.
module pid_controller_filtered_derivative #(
    parameter int FRAC_BITS = pidf_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] error_in,
    input  logic [15:0] dt_us,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] control_out,
    output logic        saturated,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import pidf_pkg::*;

    localparam int IA_W     = 32 + FRAC_BITS;           // integrator, signed
    localparam int TERM_W   = DP_W - FRAC_BITS;         // product >> FRAC_BITS
    localparam int SUM_W    = TERM_W + 1;               // signed sum of terms
    localparam int FD_DIV_N = (FRAC_BITS + 54 > 81) ? FRAC_BITS + 54 : 81;

    // Configuration
    logic [31:0] kp_reg, kp_next;
    logic [31:0] ki_reg, ki_next;
    logic [31:0] kd_reg, kd_next;
    logic [30:0] ilim_reg, ilim_next;
    logic [15:0] ft_reg, ft_next;

    // Controller state
    logic [IA_W-1:0] integ_reg, integ_next;
    logic [31:0]     prev_err_reg, prev_err_next;
    logic [63:0]     fd_reg, fd_next;
    logic            primed_reg, primed_next;

    // Sequencer
    pidf_state_t state_reg, state_next;
    logic        launched_reg, launched_next;

    // Request and work registers
    logic [2:0]       func_reg, func_next;
    logic [31:0]      err_reg, err_next;
    logic [15:0]      dt_reg, dt_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [DP_W-1:0]  tmp_reg, tmp_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] control_out_reg, control_out_next;
    logic        sat_reg, sat_next;

    // Serial unit interface
    pidf_md_cmd_t    md_cmd;
    pidf_md_sts_t    md_sts;
    logic [DP_W-1:0] md_opa;
    logic [MP_W-1:0] md_opb;
    logic [DV_W-1:0] md_dvs;
    logic [DP_W-1:0] md_result;

    // Decode and derived values
    logic            use_p, use_i, use_d, is_clear, do_i, do_d;
    pidf_state_t     p_first, i_first, d_first;
    logic [31:0]     err_mag, kp_mag, ki_mag, kd_mag;
    logic [63:0]     fd_mag;
    logic [32:0]     de, de_mag;
    logic [DP_W-1:0] a_mag;
    logic [IA_W-1:0] integ_mag, lim_w;
    logic [DP_W-1:0] integ_sx, lim_ext, lim_neg, clamped;
    logic [DV_W-1:0] filt_div;
    logic            fin_take;
    logic [SUM_W-32:0] sum_hi;
    logic            sum_fits;

    pidf_serial_md u_md (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (md_cmd),
        .opa     (md_opa),
        .opb     (md_opb),
        .divisor (md_dvs),
        .sts     (md_sts),
        .result  (md_result)
    );

    // Operation decode
    always_comb
    begin
        use_p = 1'b0;
        use_i = 1'b0;
        use_d = 1'b0;
        case (func_reg)
            FN_PID:
            begin
                use_p = 1'b1;
                use_i = 1'b1;
                use_d = 1'b1;
            end
            FN_PI:
            begin
                use_p = 1'b1;
                use_i = 1'b1;
            end
            FN_P:    use_p = 1'b1;
            FN_I:    use_i = 1'b1;
            FN_D:    use_d = 1'b1;
            default: use_p = 1'b0;
        endcase
        is_clear = (func_reg == FN_CLEAR);
        do_i     = use_i && (ki_reg != '0) && (dt_reg != '0);
        do_d     = use_d && (kd_reg != '0) && (dt_reg != '0);
        d_first  = !do_d ? S_FINISH : (primed_reg ? S_D_MUL_FT : S_D_PRIME);
        i_first  = do_i ? S_I_MUL_GAIN : d_first;
        p_first  = use_p ? S_P_MUL : i_first;
    end

    // Magnitudes and limits
    always_comb
    begin
        err_mag   = err_reg[31] ? -err_reg : err_reg;
        kp_mag    = kp_reg[31] ? -kp_reg : kp_reg;
        ki_mag    = ki_reg[31] ? -ki_reg : ki_reg;
        kd_mag    = kd_reg[31] ? -kd_reg : kd_reg;
        fd_mag    = fd_reg[63] ? -fd_reg : fd_reg;
        de        = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};
        de_mag    = de[32] ? -de : de;
        a_mag     = tmp_reg[DP_W-1] ? -tmp_reg : tmp_reg;
        integ_mag = integ_reg[IA_W-1] ? -integ_reg : integ_reg;
        integ_sx  = {{(DP_W-IA_W){integ_reg[IA_W-1]}}, integ_reg};
        lim_w     = {1'b0, ilim_reg, {FRAC_BITS{1'b0}}};
        lim_ext   = DP_W'(lim_w);
        lim_neg   = -lim_ext;
        filt_div  = DV_W'(ft_reg) + DV_W'(dt_reg);
        if ($signed(tmp_reg) > $signed(lim_ext))
        begin
            clamped = lim_ext;
        end
        else if ($signed(tmp_reg) < $signed(lim_neg))
        begin
            clamped = lim_neg;
        end
        else
        begin
            clamped = tmp_reg;
        end
        sum_hi   = sum_reg[SUM_W-1:31];
        sum_fits = (&sum_hi) || !(|sum_hi);
        fin_take = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:   state_next = is_clear ? S_FINISH : p_first;
            S_P_MUL:      state_next = md_sts.done ? i_first : S_P_MUL;
            S_I_MUL_GAIN: state_next = md_sts.done ? S_I_MUL_DT : S_I_MUL_GAIN;
            S_I_MUL_DT:   state_next = md_sts.done ? S_I_DIV : S_I_MUL_DT;
            S_I_DIV:      state_next = md_sts.done ? S_I_CLAMP : S_I_DIV;
            S_I_CLAMP:    state_next = S_I_TERM;
            S_I_TERM:     state_next = d_first;
            S_D_PRIME:    state_next = S_FINISH;
            S_D_MUL_FT:   state_next = md_sts.done ? S_D_MUL_DE : S_D_MUL_FT;
            S_D_MUL_DE:   state_next = md_sts.done ? S_D_DIV : S_D_MUL_DE;
            S_D_DIV:      state_next = md_sts.done ? S_D_MUL_KD : S_D_DIV;
            S_D_MUL_KD:   state_next = md_sts.done ? S_FINISH : S_D_MUL_KD;
            S_FINISH:     state_next = fin_take ? S_IDLE : S_FINISH;
            default:      state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and serial unit operands
    always_comb
    begin
        in_stall     = (state_reg != S_IDLE);
        md_cmd       = '0;
        md_opa       = '0;
        md_opb       = '0;
        md_dvs       = '0;
        case (state_reg)
            S_P_MUL:
            begin
                md_cmd.steps = STEP_W'(MP_W);
                md_opa       = DP_W'(err_mag);
                md_opb       = kp_mag;
            end
            S_I_MUL_GAIN:
            begin
                md_cmd.steps = STEP_W'(MP_W);
                md_opa       = DP_W'(err_mag);
                md_opb       = ki_mag;
            end
            S_I_MUL_DT:
            begin
                md_cmd.steps = STEP_W'(16);
                md_opa       = tmp_reg;
                md_opb       = MP_W'(dt_reg);
            end
            S_I_DIV:
            begin
                md_cmd.div   = 1'b1;
                md_cmd.steps = STEP_W'(I_DIV_N);
                md_opa       = tmp_reg << (DP_W - I_DIV_N);
                md_dvs       = US_PER_S;
            end
            S_D_MUL_FT:
            begin
                md_cmd.steps = STEP_W'(16);
                md_opa       = DP_W'(fd_mag);
                md_opb       = MP_W'(ft_reg);
            end
            S_D_MUL_DE:
            begin
                md_cmd.steps = STEP_W'(DV_W);
                md_opa       = DP_W'(de_mag);
                md_opb       = MP_W'(US_PER_S);
            end
            S_D_DIV:
            begin
                md_cmd.div   = 1'b1;
                md_cmd.steps = STEP_W'(FD_DIV_N);
                md_opa       = a_mag << (DP_W - FD_DIV_N);
                md_dvs       = filt_div;
            end
            S_D_MUL_KD:
            begin
                md_cmd.steps = STEP_W'(MP_W);
                md_opa       = DP_W'(fd_mag);
                md_opb       = kd_mag;
            end
            default: md_cmd.steps = '0;
        endcase
        // every state that sets a step count launches one operation
        md_cmd.start = (md_cmd.steps != '0) && !launched_reg;
    end

    // Datapath and register next values
    always_comb
    begin
        kp_next          = kp_reg;
        ki_next          = ki_reg;
        kd_next          = kd_reg;
        ilim_next        = ilim_reg;
        ft_next          = ft_reg;
        integ_next       = integ_reg;
        prev_err_next    = prev_err_reg;
        fd_next          = fd_reg;
        primed_next      = primed_reg;
        func_next        = func_reg;
        err_next         = err_reg;
        dt_next          = dt_reg;
        sum_next         = sum_reg;
        tmp_next         = tmp_reg;
        control_out_next = control_out_reg;
        sat_next         = sat_reg;

        // launch flag: set on start, cleared when the unit reports done
        if (md_cmd.start)
        begin
            launched_next = 1'b1;
        end
        else if (md_sts.done)
        begin
            launched_next = 1'b0;
        end
        else
        begin
            launched_next = launched_reg;
        end

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:   kp_next   = cfg_data;
                CFG_INTEG_GAIN:  ki_next   = cfg_data;
                CFG_DERIV_GAIN:  kd_next   = cfg_data;
                CFG_INTEG_LIMIT: ilim_next = cfg_data[30:0];
                CFG_FILTER_TIME: ft_next   = cfg_data[15:0];
                default:         kp_next   = kp_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    err_next  = error_in;
                    dt_next   = dt_us;
                end
            end
            S_DISPATCH:
            begin
                sum_next = '0;
                if (is_clear)
                begin
                    integ_next = '0;
                end
            end
            S_P_MUL:
            begin
                if (md_sts.done)
                begin
                    if (err_reg[31] ^ kp_reg[31])
                        sum_next = sum_reg - SUM_W'(md_result[DP_W-1:FRAC_BITS]);
                    else
                        sum_next = sum_reg + SUM_W'(md_result[DP_W-1:FRAC_BITS]);
                end
            end
            S_I_MUL_GAIN, S_I_MUL_DT:
            begin
                if (md_sts.done)
                begin
                    tmp_next = md_result;
                end
            end
            S_I_DIV:
            begin
                // integrator plus signed increment
                if (md_sts.done)
                begin
                    if (err_reg[31] ^ ki_reg[31])
                        tmp_next = integ_sx - DP_W'(md_result[I_DIV_N-1:0]);
                    else
                        tmp_next = integ_sx + DP_W'(md_result[I_DIV_N-1:0]);
                end
            end
            S_I_CLAMP:
            begin
                integ_next = clamped[IA_W-1:0];
            end
            S_I_TERM:
            begin
                if (integ_reg[IA_W-1])
                    sum_next = sum_reg - SUM_W'(integ_mag[IA_W-1:FRAC_BITS]);
                else
                    sum_next = sum_reg + SUM_W'(integ_mag[IA_W-1:FRAC_BITS]);
            end
            S_D_PRIME:
            begin
                // first derivative update only records history and clears the filtered derivative
                fd_next       = '0;
                primed_next   = 1'b1;
                prev_err_next = err_reg;
            end
            S_D_MUL_FT:
            begin
                if (md_sts.done)
                begin
                    tmp_next = fd_reg[63] ? -md_result : md_result;
                end
            end
            S_D_MUL_DE:
            begin
                if (md_sts.done)
                begin
                    if (de[32])
                        tmp_next = tmp_reg - (md_result << FRAC_BITS);
                    else
                        tmp_next = tmp_reg + (md_result << FRAC_BITS);
                end
            end
            S_D_DIV:
            begin
                // filtered derivative, saturated to 64 bits
                if (md_sts.done)
                begin
                    if (md_result[DP_W-1:63] != '0)
                        fd_next = tmp_reg[DP_W-1] ? 64'h8000_0000_0000_0000
                                                  : 64'h7FFF_FFFF_FFFF_FFFF;
                    else
                        fd_next = tmp_reg[DP_W-1] ? -md_result[63:0] : md_result[63:0];
                    prev_err_next = err_reg;
                end
            end
            S_D_MUL_KD:
            begin
                if (md_sts.done)
                begin
                    if (fd_reg[63] ^ kd_reg[31])
                        sum_next = sum_reg - SUM_W'(md_result[DP_W-1:FRAC_BITS]);
                    else
                        sum_next = sum_reg + SUM_W'(md_result[DP_W-1:FRAC_BITS]);
                end
            end
            S_FINISH:
            begin
                // saturate the sum to 32 bits
                if (fin_take)
                begin
                    if (sum_fits)
                    begin
                        control_out_next = sum_reg[31:0];
                        sat_next         = 1'b0;
                    end
                    else
                    begin
                        control_out_next = sum_reg[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                        sat_next         = 1'b1;
                    end
                end
            end
            default: sum_next = sum_reg;
        endcase

        // output register hand-off
        if (fin_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            ilim_reg      <= '0;
            ft_reg        <= FILTER_RESET;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            fd_reg        <= '0;
            primed_reg    <= 1'b0;
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            kp_reg        <= kp_next;
            ki_reg        <= ki_next;
            kd_reg        <= kd_next;
            ilim_reg      <= ilim_next;
            ft_reg        <= ft_next;
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            fd_reg        <= fd_next;
            primed_reg    <= primed_next;
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        err_reg         <= err_next;
        dt_reg          <= dt_next;
        sum_reg         <= sum_next;
        tmp_reg         <= tmp_next;
        control_out_reg <= control_out_next;
        sat_reg         <= sat_next;
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign control_out = control_out_reg;
    assign saturated   = sat_reg;

    // Integrator stays within the limit once clamped
    a_integ_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_I_TERM) |-> (integ_mag <= lim_w))
        else $error("integrator beyond limit after clamp");

    // Unit completion only for an operation the sequencer launched
    a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
        md_sts.done |-> launched_reg)
        else $error("serial unit done without launch");

    // No request taken while the serial unit is working
    a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !md_sts.busy)
        else $error("serial unit busy while idle");

    // Derivative history, once primed, is never lost
    a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(primed_reg))
        else $error("derivative primed flag dropped");

endmodule
